>>> rtl/ps_tx_pkg.sv
// Package for the serial printer transmitter: transaction types, command and
// register codes, and frame constants. No dependencies.
package ps_tx_pkg;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [1:0] OFF_DATA   = 2'd0;
    localparam logic [1:0] OFF_STATUS = 2'd1;
    localparam logic [1:0] OFF_MODE   = 2'd2;
    localparam logic [1:0] OFF_NONE   = 2'd3;

    // Mode register bit positions.
    localparam int MODE_DIV_ACCESS = 7;
    localparam int MODE_DIAG       = 6;
    localparam int MODE_ERR_EN     = 5;
    localparam int MODE_EMPTY_EN   = 4;
    localparam int MODE_BUSY       = 3;
    localparam logic [7:0] MODE_KEEP_MASK = 8'hfc;

    // Pending flag bit positions.
    localparam int PEND_EMPTY = 0;
    localparam int PEND_ERR   = 1;

    localparam logic [7:0]  STATUS_BASE   = 8'h50;
    localparam logic [7:0]  UNMAPPED_READ = 8'hff;
    localparam logic [3:0]  FRAME_BITS    = 4'd11;
    localparam logic [16:0] PERIOD_BASE   = 17'h10000;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] port_offset;
        logic [7:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_level;
        logic       tx_line;
    } out_item_t;

endpackage

>>> rtl/ps_tx_core.sv
// Transmitter state registers and the single-pass logic that applies one
// transaction to them. Depends on ps_tx_pkg.
module ps_tx_core
    import ps_tx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      enable,
    input  in_item_t  item,
    output out_item_t result
);

    logic [7:0]  mode_reg, mode_next;
    logic [15:0] rate_divisor_reg, rate_divisor_next;
    logic [7:0]  holding_byte_reg, holding_byte_next;
    logic        holding_full_reg, holding_full_next;
    logic [10:0] shift_word_reg, shift_word_next;
    logic [3:0]  bits_left_reg, bits_left_next;
    logic        shifting_reg, shifting_next;
    logic        line_space_reg, line_space_next;
    logic [1:0]  pending_reg, pending_next;
    logic        timer_armed_reg, timer_armed_next;
    logic [16:0] countdown_reg, countdown_next;

    function automatic logic gated(input logic [7:0] m);
        return m[MODE_DIAG] && m[MODE_BUSY];
    endfunction

    function automatic logic irq_of(input logic [7:0] m, input logic [1:0] p);
        return (p[PEND_EMPTY] && m[MODE_EMPTY_EN]) || (p[PEND_ERR] && m[MODE_ERR_EN]);
    endfunction

    // A line change while diagnostic loopback and error irq are enabled flags an error.
    function automatic logic line_err(input logic [7:0] m, input logic cur, input logic sp);
        return m[MODE_DIAG] && m[MODE_ERR_EN] && (cur != sp);
    endfunction

    always_comb
    begin
        logic [7:0] rd;
        logic [7:0] st;
        logic       sp;
        logic       load_hold;
        mode_next         = mode_reg;
        rate_divisor_next = rate_divisor_reg;
        holding_byte_next = holding_byte_reg;
        holding_full_next = holding_full_reg;
        shift_word_next   = shift_word_reg;
        bits_left_next    = bits_left_reg;
        shifting_next     = shifting_reg;
        line_space_next   = line_space_reg;
        pending_next      = pending_reg;
        timer_armed_next  = timer_armed_reg;
        countdown_next    = countdown_reg;
        rd                = 8'h00;
        st                = STATUS_BASE;
        sp                = 1'b0;
        load_hold         = 1'b0;

        unique case (item.command)
            CMD_READ:
            begin
                if (item.port_offset == OFF_NONE)
                begin
                    rd = UNMAPPED_READ;
                end
                else if (item.port_offset == OFF_MODE)
                begin
                    rd = mode_reg;
                end
                else if (mode_reg[MODE_DIV_ACCESS])
                begin
                    rd = (item.port_offset == OFF_STATUS) ? rate_divisor_reg[15:8]
                                                          : rate_divisor_reg[7:0];
                end
                else if (item.port_offset == OFF_DATA)
                begin
                    rd = holding_byte_reg;
                end
                else
                begin
                    st[7] = !holding_full_reg;
                    st[0] = (bits_left_reg <= 4'd1) && !holding_full_reg;
                    st[1] = !gated(mode_reg);
                    st[3] = !mode_reg[MODE_DIAG] || line_space_reg;
                    st[2] = irq_of(mode_reg, pending_reg);
                    rd = st;
                    pending_next = 2'b00;
                end
            end
            CMD_WRITE:
            begin
                if (item.port_offset == OFF_MODE)
                begin
                    mode_next = item.write_data & MODE_KEEP_MASK;
                    if (item.write_data[MODE_EMPTY_EN] && !mode_reg[MODE_EMPTY_EN]
                        && !holding_full_reg)
                    begin
                        pending_next[PEND_EMPTY] = 1'b1;
                    end
                    if (bits_left_reg != 4'd0 && !shifting_reg && !gated(mode_next))
                    begin
                        shifting_next = 1'b1;
                        sp = !shift_word_reg[0];
                        if (line_err(mode_next, line_space_reg, sp))
                        begin
                            pending_next[PEND_ERR] = 1'b1;
                        end
                        line_space_next  = sp;
                        timer_armed_next = 1'b1;
                        countdown_next   = PERIOD_BASE - {1'b0, rate_divisor_reg};
                    end
                end
                else if (item.port_offset == OFF_NONE)
                begin
                end
                else if (mode_reg[MODE_DIV_ACCESS])
                begin
                    if (item.port_offset == OFF_STATUS)
                    begin
                        rate_divisor_next[15:8] = item.write_data;
                    end
                    else
                    begin
                        rate_divisor_next[7:0] = item.write_data;
                    end
                end
                else if (item.port_offset == OFF_DATA)
                begin
                    holding_byte_next        = item.write_data;
                    holding_full_next        = 1'b1;
                    pending_next[PEND_EMPTY] = 1'b0;
                    if (bits_left_reg == 4'd0 && !timer_armed_reg)
                    begin
                        timer_armed_next = 1'b1;
                        countdown_next   = PERIOD_BASE - {1'b0, rate_divisor_reg};
                    end
                end
            end
            CMD_TICK:
            begin
                if (timer_armed_reg)
                begin
                    if (countdown_reg != 17'd0)
                    begin
                        countdown_next = countdown_reg - 17'd1;
                    end
                    if (countdown_next == 17'd0)
                    begin
                        timer_armed_next = 1'b0;
                        if (shifting_reg)
                        begin
                            shift_word_next = {1'b0, shift_word_reg[10:1]};
                            bits_left_next  = bits_left_reg - 4'd1;
                            if (bits_left_next != 4'd0)
                            begin
                                sp = !shift_word_next[0];
                                timer_armed_next = 1'b1;
                                countdown_next = PERIOD_BASE - {1'b0, rate_divisor_reg};
                            end
                            else
                            begin
                                shifting_next = 1'b0;
                                sp = 1'b0;
                                load_hold = 1'b1;
                            end
                            if (line_err(mode_reg, line_space_reg, sp))
                            begin
                                pending_next[PEND_ERR] = 1'b1;
                            end
                            line_space_next = sp;
                        end
                        else
                        begin
                            load_hold = 1'b1;
                        end
                        if (load_hold && holding_full_reg)
                        begin
                            shift_word_next = {2'b11, holding_byte_reg, 1'b0};
                            bits_left_next  = FRAME_BITS;
                            holding_full_next = 1'b0;
                            pending_next[PEND_EMPTY] = 1'b1;
                            if (!gated(mode_reg))
                            begin
                                shifting_next = 1'b1;
                                // The start bit is always a space.
                                if (line_err(mode_reg, line_space_next, 1'b1))
                                begin
                                    pending_next[PEND_ERR] = 1'b1;
                                end
                                line_space_next  = 1'b1;
                                timer_armed_next = 1'b1;
                                countdown_next = PERIOD_BASE - {1'b0, rate_divisor_reg};
                            end
                        end
                    end
                end
            end
            CMD_NOP:
            begin
            end
            default:
            begin
            end
        endcase

        result.read_data = rd;
        result.irq_level = irq_of(mode_next, pending_next);
        result.tx_line   = !line_space_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= '0;
            rate_divisor_reg <= '0;
            holding_byte_reg <= '0;
            holding_full_reg <= 1'b0;
            shift_word_reg   <= '0;
            bits_left_reg    <= '0;
            shifting_reg     <= 1'b0;
            line_space_reg   <= 1'b0;
            pending_reg      <= '0;
            timer_armed_reg  <= 1'b0;
            countdown_reg    <= '0;
        end
        else if (enable)
        begin
            mode_reg         <= mode_next;
            rate_divisor_reg <= rate_divisor_next;
            holding_byte_reg <= holding_byte_next;
            holding_full_reg <= holding_full_next;
            shift_word_reg   <= shift_word_next;
            bits_left_reg    <= bits_left_next;
            shifting_reg     <= shifting_next;
            line_space_reg   <= line_space_next;
            pending_reg      <= pending_next;
            timer_armed_reg  <= timer_armed_next;
            countdown_reg    <= countdown_next;
        end
    end

endmodule

>>> rtl/printer_serial_transmitter.sv
// Top level of the serial printer transmitter: input and result registers
// around the transmitter core. Depends on ps_tx_pkg and ps_tx_core.
//
// Usage: each input transaction is a bus read, a bus write or one tick of
// the 4.77 MHz timebase, carried by in_item with in_valid and in_stall.
// A transaction is taken at a rising edge with in_valid high and in_stall
// low. Every input transaction yields exactly one result transaction on
// out_item (read byte, interrupt level, serial line level), handed over at
// an edge with out_valid high and out_stall low.
// The transaction waits in the input register, then the core updates its state
// in a single pass and the result is captured in the output register.
// Throughput is one transaction per cycle while the output is not stalled, so
// a tick can be fed on every clock; the pass through the core sets that figure.
// When the receiver stalls, the result register holds its transaction and
// the input register can still take one more; in_stall rises only when
// both are occupied and the output is stalled.
// Reset clears the mode, divisor, holding and shifter state, all pending
// interrupts, and both pipeline valid flags; the line idles at mark.
module printer_serial_transmitter
    import ps_tx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    in_item_t  in_item_reg;
    logic      in_valid_reg, in_valid_next;
    out_item_t out_item_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t core_result;
    logic      advance;
    logic      in_take;

    // The core consumes the held transaction whenever the result register is free
    // or being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    ps_tx_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .enable (advance),
        .item   (in_item_reg),
        .result (core_result)
    );

    always_comb
    begin
        in_valid_next = in_take || (in_valid_reg && !advance);
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_item_reg <= core_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
